>>> rtl/rhws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rhws_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF  = 16;

    // CORDIC working width: start vector is step * K with 16 extra fraction bits
    localparam int CORDIC_XW = 50;
    localparam int CORDIC_ZW = 34;
    localparam int ATAN_IDX_BITS = 5;

    localparam logic [31:0] GAIN_Q30 = 32'd652032874;

    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 31;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_STEP_DISTANCE = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MAX_STEP      = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_ARRIVAL_TOL   = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CHECK_INTV    = 2'd3;

    localparam logic [30:0] STEP_DISTANCE_RST = 31'd65536;
    localparam logic [30:0] MAX_STEP_RST      = 31'd65536;
    localparam logic [15:0] ARRIVAL_TOL_RST   = 16'd3277;
    localparam logic [15:0] CHECK_INTV_RST    = 16'd20;

    localparam logic [1:0] EV_IDLE    = 2'd0;
    localparam logic [1:0] EV_NEW     = 2'd1;
    localparam logic [1:0] EV_REACHED = 2'd2;
    localparam logic [1:0] EV_FAR     = 2'd3;

    localparam logic [31:0] DIST_SAT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic busy;
        logic done;
    } rhws_cordic_stat_t;

    // arctan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_BITS-1:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:    r = 32'd536870912;
            5'd1:    r = 32'd316933406;
            5'd2:    r = 32'd167458907;
            5'd3:    r = 32'd85004756;
            5'd4:    r = 32'd42667331;
            5'd5:    r = 32'd21354465;
            5'd6:    r = 32'd10679838;
            5'd7:    r = 32'd5340245;
            5'd8:    r = 32'd2670163;
            5'd9:    r = 32'd1335087;
            5'd10:   r = 32'd667544;
            5'd11:   r = 32'd333772;
            5'd12:   r = 32'd166886;
            5'd13:   r = 32'd83443;
            5'd14:   r = 32'd41722;
            5'd15:   r = 32'd20861;
            5'd16:   r = 32'd10430;
            5'd17:   r = 32'd5215;
            5'd18:   r = 32'd2608;
            5'd19:   r = 32'd1304;
            5'd20:   r = 32'd652;
            5'd21:   r = 32'd326;
            5'd22:   r = 32'd163;
            5'd23:   r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rhws_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rhws_in_if
    import rhws_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic signed [POSITION_BITS-1:0] current_north;
    logic signed [POSITION_BITS-1:0] current_east;
    logic signed [POSITION_BITS-1:0] current_down;
    logic signed [ANGLE_BITS-1:0]    heading;
    logic [15:0]                     random_value;

    modport source (
        output valid, current_north, current_east, current_down, heading, random_value,
        input  ready
    );
    modport sink (
        input  valid, current_north, current_east, current_down, heading, random_value,
        output ready
    );
endinterface

interface rhws_out_if
    import rhws_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic [1:0]                      event_res;
    logic signed [POSITION_BITS-1:0] target_north;
    logic signed [POSITION_BITS-1:0] target_east;
    logic signed [POSITION_BITS-1:0] target_down;
    logic [31:0]                     distance_sq;

    modport source (
        output valid, event_res, target_north, target_east, target_down, distance_sq,
        input  ready
    );
    modport sink (
        input  valid, event_res, target_north, target_east, target_down, distance_sq,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/rhws_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module rhws_cordic
    import rhws_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [CORDIC_XW-1:0]        x_start,
    input  wire logic [31:0]                 angle,
    output logic signed [CORDIC_XW-1:0]      x_out,
    output logic signed [CORDIC_XW-1:0]      y_out,
    output rhws_cordic_stat_t                stat
);

    localparam int ITW = $clog2(CORDIC_STEPS);
    localparam logic [ITW-1:0] IT_LAST = ITW'(CORDIC_STEPS - 1);

    logic signed [CORDIC_XW-1:0] x_reg, x_next;
    logic signed [CORDIC_XW-1:0] y_reg, y_next;
    logic signed [CORDIC_ZW-1:0] z_reg, z_next;
    logic [ITW-1:0]              it_reg, it_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;

    logic [1:0]                  quadrant;
    logic [31:0]                 angle_fold;
    logic signed [CORDIC_XW-1:0] dx;
    logic signed [CORDIC_XW-1:0] dy;
    logic signed [CORDIC_ZW-1:0] atan_z;

    assign quadrant = angle[31:30];
    assign dx       = y_reg >>> it_reg;
    assign dy       = x_reg >>> it_reg;
    assign atan_z   = $signed(CORDIC_ZW'(atan_turn(ATAN_IDX_BITS'(it_reg))));

    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        it_next    = it_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        angle_fold = angle;
        if (start)
        begin
            // second and third quadrant: rotate by half a turn, negate start vector
            if (quadrant == 2'b01 || quadrant == 2'b10)
            begin
                angle_fold = angle ^ 32'h8000_0000;
                x_next     = -$signed(x_start);
            end
            else
            begin
                x_next = $signed(x_start);
            end
            y_next    = '0;
            z_next    = CORDIC_ZW'($signed(angle_fold));
            it_next   = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[CORDIC_ZW-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_z;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_z;
            end
            it_next = it_reg + 1'b1;
            if (it_reg == IT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

>>> rtl/random_heading_waypoint_stepper.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake    Word
// in_ch     in   valid/ready  current_north/east/down, heading, random_value
// out_ch    out  valid/ready  event_res, target_north/east/down, distance_sq
// cfg       in   cfg_we       cfg_addr, cfg_wdata (write only)
//
// One word at a time. A new target is computed by the iterative CORDIC
// (one micro-rotation per cycle). A held target runs the serial remainder
// of tick_count (one bit per cycle), and on a check tick also uses the
// shared 32x32 multiplier three times, then sums and compares.
// Input is taken again as soon as the sequencer is back in idle, even if the
// last result still waits in the output register.
// Async active-low reset clears control state and the held target and loads the config defaults.

module random_heading_waypoint_stepper
    import rhws_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
    rhws_in_if.sink                       in_ch,
    rhws_out_if.source                    out_ch
);

    localparam int PB = POSITION_BITS;
    localparam int AB = ANGLE_BITS;
    localparam int CW = CORDIC_XW - 16;
    localparam int SW = ((PB > CW) ? PB : CW) + 1;
    localparam int AW = ((PB + 1) > 33) ? (PB + 1) : 33;

    localparam logic [SW-1:0] POS_HI = {{(SW - PB + 1){1'b0}}, {(PB - 1){1'b1}}};
    localparam logic [SW-1:0] POS_LO = ~POS_HI;
    localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL    = 4'd1;
    localparam logic [3:0] S_ROT_GO = 4'd2;
    localparam logic [3:0] S_ROT    = 4'd3;
    localparam logic [3:0] S_FINISH = 4'd4;
    localparam logic [3:0] S_REM    = 4'd5;
    localparam logic [3:0] S_DIFF   = 4'd6;
    localparam logic [3:0] S_SQN    = 4'd7;
    localparam logic [3:0] S_SQE    = 4'd8;
    localparam logic [3:0] S_SQT    = 4'd9;
    localparam logic [3:0] S_SUM    = 4'd10;
    localparam logic [3:0] S_CMP    = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic [3:0]  state_reg, state_next;

    logic [30:0] step_dist_reg;
    logic [30:0] max_step_reg;
    logic [15:0] tol_reg;
    logic [15:0] intv_reg;

    logic signed [PB-1:0] cn_reg, ce_reg, cd_reg;
    logic signed [AB-1:0] head_reg;
    logic [15:0]          rnd_reg;

    logic [15:0] tick_reg, tick_next;
    logic        held_reg, held_next;
    logic signed [PB-1:0] tn_reg, tn_next;
    logic signed [PB-1:0] te_reg, te_next;
    logic signed [PB-1:0] td_reg, td_next;

    logic [31:0] turn_reg, turn_next;
    logic [16:0] rem_reg, rem_next;
    logic [3:0]  rbit_reg, rbit_next;
    logic [31:0] an_reg, an_next;
    logic [31:0] ae_reg, ae_next;
    logic        big_reg, big_next;
    logic [63:0] sqn_reg, sqn_next;
    logic [63:0] sqe_reg, sqe_next;
    logic [31:0] tolsq_reg, tolsq_next;
    logic [64:0] total_reg, total_next;
    logic [1:0]  ev_reg, ev_next;
    logic [31:0] dist_reg, dist_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_prod_reg, mul_prod_next;

    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_ev_reg;
    logic signed [PB-1:0] out_tn_reg, out_te_reg, out_td_reg;
    logic [31:0]          out_dist_reg;
    logic                 out_load;

    logic                        in_fire;
    logic [30:0]                 step;
    logic [15:0]                 iv;
    logic [14+AB:0]              rnd_wide;
    logic [AB-1:0]               ang;
    logic [16:0]                 rem_sh;
    logic                        cordic_start;
    logic signed [CORDIC_XW-1:0] cx, cy;
    logic signed [CORDIC_XW-1:0] cx_rnd, cy_rnd;
    logic signed [CW-1:0]        cs, sn;
    logic signed [SW-1:0]        sum_n, sum_e;
    logic signed [AW-1:0]        d_n, d_e;
    logic [AW-1:0]               abs_n, abs_e;
    rhws_cordic_stat_t           cordic_stat;

    rhws_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .x_start (CORDIC_XW'(mul_prod_reg[60:14])),
        .angle   (turn_reg),
        .x_out   (cx),
        .y_out   (cy),
        .stat    (cordic_stat)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign step = (step_dist_reg < max_step_reg) ? step_dist_reg : max_step_reg;
    assign iv   = (intv_reg == 16'd0) ? 16'd1 : intv_reg;

    // heading + random * half turn - quarter turn
    assign rnd_wide = {rnd_reg, {(AB - 1){1'b0}}};
    assign ang      = head_reg + AB'(rnd_wide[14+AB:16]) - QUARTER;

    assign rem_sh = {rem_reg[15:0], tick_reg[rbit_reg]};

    // round half up to Q16.16
    assign cx_rnd = cx + CORDIC_XW'(32'sd32768);
    assign cy_rnd = cy + CORDIC_XW'(32'sd32768);
    assign cs     = cx_rnd[CORDIC_XW-1:16];
    assign sn     = cy_rnd[CORDIC_XW-1:16];
    assign sum_n  = SW'(cn_reg) + SW'(cs);
    assign sum_e  = SW'(ce_reg) + SW'(sn);

    assign d_n   = AW'(tn_reg) - AW'(cn_reg);
    assign d_e   = AW'(te_reg) - AW'(ce_reg);
    assign abs_n = d_n[AW-1] ? AW'(-d_n) : AW'(d_n);
    assign abs_e = d_e[AW-1] ? AW'(-d_e) : AW'(d_e);

    assign cordic_start = (state_reg == S_ROT_GO);

    always_comb
    begin
        unique case (state_reg)
            S_MUL:
            begin
                mul_a = {1'b0, step};
                mul_b = GAIN_Q30;
            end
            S_SQN:
            begin
                mul_a = an_reg;
                mul_b = an_reg;
            end
            S_SQE:
            begin
                mul_a = ae_reg;
                mul_b = ae_reg;
            end
            default:
            begin
                mul_a = {16'd0, tol_reg};
                mul_b = {16'd0, tol_reg};
            end
        endcase
        mul_prod_next = mul_a * mul_b;
    end

    always_comb
    begin
        state_next     = state_reg;
        tick_next      = tick_reg;
        held_next      = held_reg;
        tn_next        = tn_reg;
        te_next        = te_reg;
        td_next        = td_reg;
        turn_next      = turn_reg;
        rem_next       = rem_reg;
        rbit_next      = rbit_reg;
        an_next        = an_reg;
        ae_next        = ae_reg;
        big_next       = big_reg;
        sqn_next       = sqn_reg;
        sqe_next       = sqe_reg;
        tolsq_next     = tolsq_reg;
        total_next     = total_reg;
        ev_next        = ev_reg;
        dist_next      = dist_reg;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    tick_next = tick_reg + 16'd1;
                    rem_next  = '0;
                    rbit_next = 4'd15;
                    state_next = held_reg ? S_REM : S_MUL;
                end
            end
            S_MUL:
            begin
                turn_next  = {ang, {(32 - AB){1'b0}}};
                state_next = S_ROT_GO;
            end
            S_ROT_GO:
            begin
                state_next = S_ROT;
            end
            S_ROT:
            begin
                if (cordic_stat.done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if ($signed(sum_n) > $signed(POS_HI))
                    tn_next = POS_HI[PB-1:0];
                else if ($signed(sum_n) < $signed(POS_LO))
                    tn_next = POS_LO[PB-1:0];
                else
                    tn_next = sum_n[PB-1:0];
                if ($signed(sum_e) > $signed(POS_HI))
                    te_next = POS_HI[PB-1:0];
                else if ($signed(sum_e) < $signed(POS_LO))
                    te_next = POS_LO[PB-1:0];
                else
                    te_next = sum_e[PB-1:0];
                td_next    = cd_reg;
                held_next  = 1'b1;
                ev_next    = EV_NEW;
                dist_next  = '0;
                state_next = S_DONE;
            end
            S_REM:
            begin
                // restoring remainder of tick_count by the interval
                if (rem_sh >= {1'b0, iv})
                    rem_next = rem_sh - {1'b0, iv};
                else
                    rem_next = rem_sh;
                rbit_next = rbit_reg - 4'd1;
                if (rbit_reg == 4'd0)
                begin
                    if (rem_next == 17'd0)
                    begin
                        state_next = S_DIFF;
                    end
                    else
                    begin
                        ev_next    = EV_IDLE;
                        dist_next  = '0;
                        state_next = S_DONE;
                    end
                end
            end
            S_DIFF:
            begin
                an_next    = abs_n[31:0];
                ae_next    = abs_e[31:0];
                big_next   = (|abs_n[AW-1:32]) || (|abs_e[AW-1:32]);
                state_next = S_SQN;
            end
            S_SQN:
            begin
                state_next = S_SQE;
            end
            S_SQE:
            begin
                sqn_next   = mul_prod_reg;
                state_next = S_SQT;
            end
            S_SQT:
            begin
                sqe_next   = mul_prod_reg;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                tolsq_next = mul_prod_reg[31:0];
                total_next = {1'b0, sqn_reg} + {1'b0, sqe_reg};
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (big_reg || (|total_reg[64:48]))
                    dist_next = DIST_SAT;
                else
                    dist_next = total_reg[47:16];
                if (!big_reg && (total_reg <= {33'd0, tolsq_reg}))
                begin
                    held_next = 1'b0;
                    ev_next   = EV_REACHED;
                end
                else
                begin
                    ev_next = EV_FAR;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_reg      <= '0;
            held_reg      <= 1'b0;
            tn_reg        <= '0;
            te_reg        <= '0;
            td_reg        <= '0;
            out_valid_reg <= 1'b0;
            step_dist_reg <= STEP_DISTANCE_RST;
            max_step_reg  <= MAX_STEP_RST;
            tol_reg       <= ARRIVAL_TOL_RST;
            intv_reg      <= CHECK_INTV_RST;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            held_reg      <= held_next;
            tn_reg        <= tn_next;
            te_reg        <= te_next;
            td_reg        <= td_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_STEP_DISTANCE: step_dist_reg <= cfg_wdata;
                    CFG_MAX_STEP:      max_step_reg  <= cfg_wdata;
                    CFG_ARRIVAL_TOL:   tol_reg       <= cfg_wdata[15:0];
                    CFG_CHECK_INTV:    intv_reg      <= cfg_wdata[15:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cn_reg   <= in_ch.current_north;
            ce_reg   <= in_ch.current_east;
            cd_reg   <= in_ch.current_down;
            head_reg <= in_ch.heading;
            rnd_reg  <= in_ch.random_value;
        end
        mul_prod_reg <= mul_prod_next;
        turn_reg     <= turn_next;
        rem_reg      <= rem_next;
        rbit_reg     <= rbit_next;
        an_reg       <= an_next;
        ae_reg       <= ae_next;
        big_reg      <= big_next;
        sqn_reg      <= sqn_next;
        sqe_reg      <= sqe_next;
        tolsq_reg    <= tolsq_next;
        total_reg    <= total_next;
        ev_reg       <= ev_next;
        dist_reg     <= dist_next;
        if (out_load)
        begin
            out_ev_reg   <= ev_reg;
            out_tn_reg   <= tn_reg;
            out_te_reg   <= te_reg;
            out_td_reg   <= td_reg;
            out_dist_reg <= dist_reg;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.event_res    = out_ev_reg;
    assign out_ch.target_north = out_tn_reg;
    assign out_ch.target_east  = out_te_reg;
    assign out_ch.target_down  = out_td_reg;
    assign out_ch.distance_sq  = out_dist_reg;

endmodule

`default_nettype wire

>>> rtl/rhws_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rhws_checker
    import rhws_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  event_res,
    input wire logic [31:0] distance_sq
);

    // a stalled result word stays valid with event_res and distance_sq stable
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(distance_sq))
        else $error("result word changed while stalled");

    // distance only reported on check ticks
    a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_IDLE || event_res == EV_NEW) |-> distance_sq == 32'd0)
        else $error("distance nonzero on idle or new-target word");

    // one word in flight: busy right after taking a word
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken back to back");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind random_heading_waypoint_stepper rhws_checker u_rhws_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .event_res   (out_ch.event_res),
    .distance_sq (out_ch.distance_sq)
);

`default_nettype wire

>>> test/random_heading_waypoint_stepper_tb.sv
`timescale 1ns / 1ps

module random_heading_waypoint_stepper_tb;
    import rhws_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ROT_STEPS      = 16;
    localparam int MAX_PRINTED    = 40;

    localparam longint unsigned K_Q30 = 64'd652032874;

    // arctan(2^-i), units of 2^-32 turn
    localparam longint ATAN_TURN [ROT_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    typedef struct {
        logic signed [31:0] north;
        logic signed [31:0] east;
        logic signed [31:0] down;
        logic signed [15:0] heading;
        logic [15:0]        rnd;
    } nav_word_t;

    typedef struct {
        logic [1:0]         ev;
        logic signed [31:0] tn;
        logic signed [31:0] te;
        logic signed [31:0] td;
        logic [31:0]        dsq;
    } wp_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;

    rhws_in_if  in_ch ();
    rhws_out_if out_ch ();

    random_heading_waypoint_stepper u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // register shadow
    logic [30:0] step_dist_r;
    logic [30:0] max_step_r;
    logic [15:0] tol_r;
    logic [15:0] intv_r;

    // copy of the block state
    logic               held_r;
    logic [15:0]        tick_r;
    logic signed [31:0] tgt_n;
    logic signed [31:0] tgt_e;
    logic signed [31:0] tgt_d;

    wp_result_t waypoint_q [$];

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int n_words       = 0;
    int n_results     = 0;
    int n_errors      = 0;
    int n_new         = 0;
    int n_reached     = 0;
    int n_far         = 0;
    int n_idle        = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic signed [31:0] clamp_pos(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (v < 64'shFFFF_FFFF_8000_0000)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    // rotate (step*K, 0) by turn (2^-32 turn units); rounded Q16.16 cos/sin parts
    function automatic void cordic_rotate(input logic [30:0] step, input logic [31:0] turn,
                                          output longint cs, output longint sn);
        longint x, y, z, dx, dy;
        logic [31:0] a;
        longint unsigned prod;
        prod = longint'(step) * K_Q30;
        x = longint'(prod >> 14);
        y = 0;
        a = turn;
        // fold the back half-plane
        if (a[31:30] == 2'b01 || a[31:30] == 2'b10)
        begin
            a = a - 32'h8000_0000;
            x = -x;
        end
        z = longint'($signed(a));
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TURN[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TURN[i];
            end
        end
        cs = (x + 64'sd32768) >>> 16;
        sn = (y + 64'sd32768) >>> 16;
    endfunction

    function automatic wp_result_t waypoint_tick(input nav_word_t w);
        wp_result_t r;
        logic [30:0] step;
        logic [15:0] ang;
        logic [15:0] intv;
        longint cs, sn, dn, de;
        longint unsigned an, ae, sqn, sqe, sum, lows, tol2;
        logic hit;
        tick_r = tick_r + 16'd1;
        intv = (intv_r == 16'd0) ? 16'd1 : intv_r;
        r.ev = EV_IDLE;
        r.dsq = '0;
        if (!held_r)
        begin
            step = (step_dist_r < max_step_r) ? step_dist_r : max_step_r;
            ang = w.heading + (w.rnd >> 1) - 16'd16384;
            cordic_rotate(step, {ang, 16'h0000}, cs, sn);
            tgt_n = clamp_pos(longint'(w.north) + cs);
            tgt_e = clamp_pos(longint'(w.east) + sn);
            tgt_d = w.down;
            held_r = 1'b1;
            r.ev = EV_NEW;
        end
        else if (tick_r % intv == 16'd0)
        begin
            dn = longint'(tgt_n) - longint'(w.north);
            de = longint'(tgt_e) - longint'(w.east);
            an = (dn < 0) ? -dn : dn;
            ae = (de < 0) ? -de : de;
            sqn = an * an;
            sqe = ae * ae;
            sum = (sqn >> 16) + (sqe >> 16);
            lows = (sqn & 64'hFFFF) + (sqe & 64'hFFFF);
            sum = sum + (lows >> 16);
            r.dsq = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            // exact Q32.32 compare against tolerance squared
            tol2 = longint'(tol_r) * longint'(tol_r);
            hit = ((sum >> 32) == 0) && (((sum << 16) | (lows & 64'hFFFF)) <= tol2);
            if (hit)
            begin
                held_r = 1'b0;
                r.ev = EV_REACHED;
            end
            else
                r.ev = EV_FAR;
        end
        r.tn = tgt_n;
        r.te = tgt_e;
        r.td = tgt_d;
        return r;
    endfunction

    task automatic report(input string what);
        n_errors++;
        if (n_errors <= MAX_PRINTED)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic send_word(input logic [31:0] n, input logic [31:0] e, input logic [31:0] d,
                             input logic [15:0] h, input logic [15:0] r);
        nav_word_t w;
        w.north = n;
        w.east = e;
        w.down = d;
        w.heading = h;
        w.rnd = r;
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.current_north = w.north;
        in_ch.current_east = w.east;
        in_ch.current_down = w.down;
        in_ch.heading = w.heading;
        in_ch.random_value = w.rnd;
        in_ch.valid = 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        waypoint_q.push_back(waypoint_tick(w));
        n_words++;
    endtask

    task automatic visit_target();
        send_word(tgt_n, tgt_e, $urandom, $urandom, $urandom);
    endtask

    task automatic settle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (waypoint_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = addr;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (addr)
            CFG_STEP_DISTANCE: step_dist_r = data;
            CFG_MAX_STEP:      max_step_r = data;
            CFG_ARRIVAL_TOL:   tol_r = data[15:0];
            CFG_CHECK_INTV:    intv_r = data[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [30:0] step, input logic [30:0] maxs,
                                input logic [15:0] tol, input logic [15:0] intv);
        settle();
        write_reg(CFG_STEP_DISTANCE, step);
        write_reg(CFG_MAX_STEP, maxs);
        write_reg(CFG_ARRIVAL_TOL, {15'd0, tol});
        write_reg(CFG_CHECK_INTV, {15'd0, intv});
    endtask

    task automatic random_config();
        logic [30:0] s, m;
        logic [15:0] t, c;
        case ($urandom_range(7))
            0, 1, 2, 3: s = $urandom_range(31'h40000);
            4, 5:       s = $urandom;
            6:          s = 31'h7FFF_FFFF;
            default:    s = '0;
        endcase
        case ($urandom_range(7))
            0, 1, 2, 3: m = $urandom_range(31'h40000);
            4, 5:       m = $urandom;
            6:          m = 31'h7FFF_FFFF;
            default:    m = '0;
        endcase
        case ($urandom_range(7))
            0, 1, 2, 3: t = $urandom;
            4:          t = 16'hFFFF;
            5:          t = '0;
            default:    t = $urandom_range(4000);
        endcase
        case ($urandom_range(7))
            0, 1, 2, 3, 4: c = $urandom_range(4, 1);
            5:             c = '0;
            default:       c = $urandom_range(40, 5);
        endcase
        apply_config(s, m, t, c);
    endtask

    // mostly approaches to the held target, some exact hits, rest noise
    task automatic random_word();
        int unsigned k;
        logic [31:0] span, dn, de;
        k = $urandom_range(9);
        if (held_r && k < 6)
        begin
            span = tol_r + (tol_r >> 1) + 4;
            dn = $urandom_range(2 * span) - span;
            de = $urandom_range(2 * span) - span;
            send_word(tgt_n + dn, tgt_e + de, $urandom, $urandom, $urandom);
        end
        else if (held_r && k == 6)
            visit_target();
        else
            send_word($urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic test_directed();
        // reset settings: straight-ahead step, then an unchecked held tick
        send_word(32'h0, 32'h0, 32'h0, 16'h0000, 16'h8000);
        send_word(32'h0, 32'h0, 32'h0, 16'h0000, 16'h8000);
        // zero interval acts as one: every held tick checks
        apply_config(31'd65536, 31'd65536, 16'd3277, 16'd0);
        send_word(32'h0, 32'h0, 32'h0, 16'h0000, 16'h8000);
        visit_target();
        // heading and random extremes
        send_word(32'h0001_0000, 32'hFFFF_FFFF, 32'h8000_0000, 16'h8000, 16'h0000);
        visit_target();
        send_word(32'hFFFF_0000, 32'h0000_0001, 32'h7FFF_FFFF, 16'h7FFF, 16'hFFFF);
        visit_target();
        // longest step: targets saturate at the position range
        apply_config(31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF, 16'd1);
        send_word(32'h7FFF_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000, 16'h8000);
        send_word(32'h8000_0000, 32'h8000_0000, 32'h0, 16'h0000, 16'h0000);
        visit_target();
        send_word(32'h8000_0000, 32'h8000_0000, 32'h0, 16'h8000, 16'h8000);
        visit_target();
        send_word(32'h0, 32'h7FFF_FFFF, 32'h0, 16'h4000, 16'h8000);
        visit_target();
        send_word(32'h0, 32'h8000_0000, 32'h0, 16'hC000, 16'h8000);
        visit_target();
        // zero step, zero tolerance: target lands on the position
        apply_config(31'd0, 31'h7FFF_FFFF, 16'd0, 16'd1);
        send_word($urandom, $urandom, $urandom, $urandom, $urandom);
        visit_target();
        // max_step limits the step; distance right at the tolerance boundary
        apply_config(31'h7FFF_FFFF, 31'd196608, 16'd100, 16'd1);
        send_word(32'h0, 32'h0, 32'h0, $urandom, $urandom);
        send_word(tgt_n + 32'd100, tgt_e + 32'd1, 32'h0, $urandom, $urandom);
        send_word(tgt_n + 32'd100, tgt_e, 32'h0, $urandom, $urandom);
    endtask

    // interval a few dozen ticks ahead: only the tick landing on it checks
    task automatic test_long_interval();
        logic [15:0] goal;
        goal = tick_r + 16'd40;
        apply_config(31'd65536, 31'd65536, 16'd0, goal);
        if (!held_r)
            send_word($urandom, $urandom, $urandom, $urandom, $urandom);
        while (tick_r != goal - 16'd1)
            send_word(tgt_n ^ 32'h4000_0000, tgt_e, $urandom, $urandom, $urandom);
        visit_target();
        send_word($urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
        random_config();
        src_idle_pct = idle_pct;
        snk_stall_pct = stall_pct;
        repeat (count / 2) random_word();
        random_config();
        repeat (count - count / 2) random_word();
    endtask

    always @(posedge clk)
    begin : result_check
        wp_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            n_results++;
            if (waypoint_q.size() == 0)
                report("result word with nothing pending");
            else
            begin
                want = waypoint_q.pop_front();
                if (out_ch.event_res !== want.ev)
                    report($sformatf("event_res %0d, want %0d", out_ch.event_res, want.ev));
                if (out_ch.target_north !== want.tn)
                    report($sformatf("target_north %h, want %h", out_ch.target_north, want.tn));
                if (out_ch.target_east !== want.te)
                    report($sformatf("target_east %h, want %h", out_ch.target_east, want.te));
                if (out_ch.target_down !== want.td)
                    report($sformatf("target_down %h, want %h", out_ch.target_down, want.td));
                if (out_ch.distance_sq !== want.dsq)
                    report($sformatf("distance_sq %h, want %h", out_ch.distance_sq, want.dsq));
                case (want.ev)
                    EV_NEW:     n_new++;
                    EV_REACHED: n_reached++;
                    EV_FAR:     n_far++;
                    default:    n_idle++;
                endcase
            end
        end
    end

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready = ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d words still pending",
                 WATCHDOG_LIMIT, waypoint_q.size());
        $display("[random_heading_waypoint_stepper] ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.current_north = '0;
        in_ch.current_east = '0;
        in_ch.current_down = '0;
        in_ch.heading = '0;
        in_ch.random_value = '0;
        step_dist_r = 31'd65536;
        max_step_r = 31'd65536;
        tol_r = 16'd3277;
        intv_r = 16'd20;
        held_r = 1'b0;
        tick_r = '0;
        tgt_n = '0;
        tgt_e = '0;
        tgt_d = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_long_interval();
        test_random_phase(0, 0, 400);
        test_random_phase(74, 0, 400);
        test_random_phase(0, 74, 400);
        test_random_phase(11, 11, 400);

        settle();
        repeat (30) @(posedge clk);
        $display("covered %0d words in, %0d results: %0d new targets, %0d reached, %0d far,",
                 n_words, n_results, n_new, n_reached, n_far);
        $display("%0d idle ticks, a long check interval, saturation and four idle/stall mixes",
                 n_idle);
        if (n_errors == 0)
            $display("[random_heading_waypoint_stepper] OK");
        else
            $display("[random_heading_waypoint_stepper] ERROR");
        $finish;
    end

endmodule
